// ===== rtl/core/glmm_pkg.sv =====
package glmm_pkg;

   localparam int MAX_SIDE_DEFAULT = 256;
   localparam int GRID_SIZE_W      = 9;
   localparam int PIXEL_W          = 8;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [PIXEL_W-1:0] CAVITY_MARK = 8'd88;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type out_pixel;
      logic      end_of_row;
      logic      end_of_grid;
      logic      last_of_run;
   } result_type;

   // pixels read from the row stores for the column about to be taken
   typedef struct packed {
      pixel_type center;
      pixel_type up;
      pixel_type right;
   } row_taps_type;

   typedef enum logic [1:0] {
      PUSH_NONE = 2'd0,
      PUSH_ONE  = 2'd1,
      PUSH_TWO  = 2'd2
   } push_count_type;

endpackage

// ===== rtl/core/glmm_row_buffer.sv =====
module glmm_row_buffer #(
   parameter int MAX_SIDE = glmm_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_SIDE)-1:0] wr_addr,
   input  glmm_pkg::pixel_type         wr_pixel,
   input  glmm_pkg::pixel_type         wr_older,
   input  logic [$clog2(MAX_SIDE)-1:0] rd_addr,
   output glmm_pkg::row_taps_type      rd_taps
);

   localparam int IDX_W = $clog2(MAX_SIDE);

   glmm_pkg::pixel_type previous_mem [MAX_SIDE];
   glmm_pkg::pixel_type older_mem    [MAX_SIDE];

   logic [IDX_W-1:0] right_addr;

   // right neighbour column; past the last column the value is never used
   always_comb begin
      if (rd_addr == IDX_W'(MAX_SIDE - 1)) begin
         right_addr = '0;
      end else begin
         right_addr = rd_addr + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         previous_mem[wr_addr] <= wr_pixel;
         older_mem[wr_addr]    <= wr_older;
      end
      rd_taps.center <= previous_mem[rd_addr];
      rd_taps.up     <= older_mem[rd_addr];
      rd_taps.right  <= previous_mem[right_addr];
   end

endmodule

// ===== rtl/core/glmm_out_queue.sv =====
module glmm_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  glmm_pkg::push_count_type push_cnt,
   input  glmm_pkg::result_type     push_a,
   input  glmm_pkg::result_type     push_b,
   output logic                     no_room,
   output logic                     out_valid,
   output glmm_pkg::result_type     out_data,
   input  logic                     out_stall
);

   localparam int DEPTH = glmm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   glmm_pkg::result_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] push_num;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // hold the input side unless a full two-result transaction fits
   assign no_room   = (count_ff > CNT_W'(DEPTH - 2));

   always_comb begin
      case (push_cnt)
         glmm_pkg::PUSH_NONE: push_num = CNT_W'(0);
         glmm_pkg::PUSH_ONE:  push_num = CNT_W'(1);
         glmm_pkg::PUSH_TWO:  push_num = CNT_W'(2);
         default:             push_num = CNT_W'(0);
      endcase
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_num);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + push_num - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt == glmm_pkg::PUSH_ONE || push_cnt == glmm_pkg::PUSH_TWO) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_cnt == glmm_pkg::PUSH_TWO) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push_b;
      end
   end

endmodule

// ===== rtl/core/grid_local_max_marker_core.sv =====
// Four-neighbour local maximum marker for a square grid of byte pixels sent in
// raster order. csr_grid_size sets the side (0 reads as 1, values above MAX_SIDE
// are clamped) and restarts the grid; write it only while the block is idle.
// An interior pixel strictly greater than its four neighbours comes out as 'X'
// (88), every other pixel unchanged. A pixel is released when the pixel below
// it is taken; in the last row each transaction also releases itself, so that
// row yields two results per pixel. Rate: one pixel per cycle while req_stall is
// low, set by the single write port of the two row stores (MAX_SIDE x 8 bits
// each, registered reads at the next column); in the last row the rate is set
// by the result port, which drains one result per cycle from a four-entry queue
// while rsp_stall is low. Results are registered in that queue before they leave.
// The row stores need no clearing pass: no entry is used before it is written.
module grid_local_max_marker_core #(
   parameter int MAX_SIDE = glmm_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [glmm_pkg::GRID_SIZE_W-1:0]  csr_grid_size,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [glmm_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [glmm_pkg::PIXEL_W-1:0]      rsp_out_pixel,
   output logic                              rsp_end_of_row,
   output logic                              rsp_end_of_grid,
   output logic                              rsp_last_of_run
);

   localparam int IDX_W = $clog2(MAX_SIDE);
   localparam int EXT_W = (glmm_pkg::GRID_SIZE_W > IDX_W + 1) ?
                          glmm_pkg::GRID_SIZE_W : IDX_W + 1;

   logic [IDX_W-1:0] side_last_ff, side_last_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   glmm_pkg::pixel_type left_ff;

   logic [EXT_W-1:0]        size_ext;
   logic                    csr_write;
   logic                    accept;
   logic                    end_row;
   logic                    last_row;
   logic                    has_above;
   logic                    interior;
   logic                    cavity;
   logic                    no_room;
   glmm_pkg::row_taps_type  taps;
   glmm_pkg::result_type    res_above;
   glmm_pkg::result_type    res_self;
   glmm_pkg::result_type    push_a;
   glmm_pkg::result_type    push_b;
   glmm_pkg::result_type    head;
   glmm_pkg::push_count_type push_cnt;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = no_room;
   assign accept    = req_valid && !req_stall;

   assign size_ext = EXT_W'(csr_grid_size);

   always_comb begin
      if (size_ext == '0) begin
         side_last_in = '0;
      end else if (size_ext > EXT_W'(MAX_SIDE)) begin
         side_last_in = IDX_W'(MAX_SIDE - 1);
      end else begin
         side_last_in = IDX_W'(size_ext - EXT_W'(1));
      end
   end

   assign end_row   = (col_ff == side_last_ff);
   assign last_row  = (row_ff == side_last_ff);
   assign has_above = (row_ff != '0);
   // the pixel above must itself be off the top and bottom rows, and off the sides
   assign interior  = (row_ff >= IDX_W'(2)) && (col_ff != '0) && !end_row;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_write) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (end_row) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         if (csr_write) begin
            side_last_ff <= side_last_in;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // the centre of one column is the left neighbour of the next
   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= taps.center;
      end
   end

   glmm_row_buffer #(
      .MAX_SIDE (MAX_SIDE)
   ) u_row_buffer (
      .clock    (clock),
      .wr_en    (accept),
      .wr_addr  (col_ff),
      .wr_pixel (req_pixel),
      .wr_older (taps.center),
      .rd_addr  (col_in),
      .rd_taps  (taps)
   );

   assign cavity = interior
                   && (taps.center > taps.up)
                   && (taps.center > left_ff)
                   && (taps.center > taps.right)
                   && (taps.center > req_pixel);

   always_comb begin
      res_above.out_pixel   = cavity ? glmm_pkg::CAVITY_MARK : taps.center;
      res_above.end_of_row  = end_row;
      res_above.end_of_grid = 1'b0;
      res_above.last_of_run = !last_row;

      res_self.out_pixel    = req_pixel;
      res_self.end_of_row   = end_row;
      res_self.end_of_grid  = end_row;
      res_self.last_of_run  = 1'b1;

      push_a   = has_above ? res_above : res_self;
      push_b   = res_self;
      push_cnt = glmm_pkg::PUSH_NONE;
      if (accept) begin
         if (has_above && last_row) begin
            push_cnt = glmm_pkg::PUSH_TWO;
         end else if (has_above || last_row) begin
            push_cnt = glmm_pkg::PUSH_ONE;
         end
      end
   end

   glmm_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_a    (push_a),
      .push_b    (push_b),
      .no_room   (no_room),
      .out_valid (rsp_valid),
      .out_data  (head),
      .out_stall (rsp_stall)
   );

   assign rsp_out_pixel   = head.out_pixel;
   assign rsp_end_of_row  = head.end_of_row;
   assign rsp_end_of_grid = head.end_of_grid;
   assign rsp_last_of_run = head.last_of_run;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int SIDE_MAX    = glmm_pkg::MAX_SIDE_DEFAULT;
   localparam int SETTLE      = 8;
   localparam int LONG_HOLD   = 400;
   localparam int QUIET_LIMIT = 4000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [glmm_pkg::GRID_SIZE_W-1:0] csr_grid_size = '0;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [glmm_pkg::PIXEL_W-1:0]     req_pixel = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [glmm_pkg::PIXEL_W-1:0]     rsp_out_pixel;
   logic                             rsp_end_of_row;
   logic                             rsp_end_of_grid;
   logic                             rsp_last_of_run;

   grid_local_max_marker_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_grid_size   (csr_grid_size),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_grid (rsp_end_of_grid),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // predictor state: the side register, both line stores and the raster position
   logic [glmm_pkg::GRID_SIZE_W-1:0] side_reg = 9'd1;
   glmm_pkg::pixel_type              line_prev [SIDE_MAX];
   glmm_pkg::pixel_type              line_older [SIDE_MAX];
   int                               row_at = 0;
   int                               col_at = 0;

   glmm_pkg::pixel_type  raster_in [$];
   glmm_pkg::result_type marked_due [$];

   int  req_idle_pct = 31;
   int  rsp_idle_pct = 65;
   bit  long_hold_go = 1'b0;
   int  hold_count = 0;
   int  quiet_cycles = 0;
   int  mismatches = 0;
   int  pixels_taken = 0;
   int  results_seen = 0;
   int  cavities_due = 0;
   int  sizes_written = 0;
   glmm_pkg::result_type got;
   glmm_pkg::result_type want;

   // work out the results released by one accepted pixel
   function automatic void mark_cavities(input glmm_pkg::pixel_type px);
      int                   side;
      int                   r;
      int                   c;
      bit                   last_row;
      bit                   eor;
      bit                   marked;
      glmm_pkg::pixel_type  centre;
      glmm_pkg::result_type res;
      side = int'(side_reg);
      if (side == 0) side = 1;
      if (side > SIDE_MAX) side = SIDE_MAX;
      r = row_at;
      c = col_at;
      last_row = (r + 1 == side);
      eor = (c + 1 == side);
      if (r >= side || c >= side) begin
         r = 0;
         c = 0;
      end
      if (r >= 1) begin
         centre = line_prev[c];
         // interior only: the pixel above must itself be off the top and bottom rows
         marked = (r >= 2) && (r + 1 <= side) && (c >= 1) && (c + 2 <= side)
            && (centre > line_older[c]) && (centre > line_older[c-1])
            && (centre > line_prev[c+1]) && (centre > px);
         res.out_pixel   = marked ? glmm_pkg::CAVITY_MARK : centre;
         res.end_of_row  = eor;
         res.end_of_grid = 1'b0;
         res.last_of_run = !last_row;
         marked_due = {marked_due, res};
         if (marked) cavities_due++;
      end
      line_older[c] = line_prev[c];
      line_prev[c] = px;
      if (last_row) begin
         res.out_pixel   = px;
         res.end_of_row  = eor;
         res.end_of_grid = eor;
         res.last_of_run = 1'b1;
         marked_due = {marked_due, res};
      end
      if (eor) begin
         col_at = 0;
         row_at = last_row ? 0 : r + 1;
      end else begin
         col_at = c + 1;
         row_at = r;
      end
   endfunction

   function automatic glmm_pkg::pixel_type pick_pixel();
      case ($urandom_range(3))
         0: pick_pixel = glmm_pkg::pixel_type'($urandom_range(100, 102));
         1: pick_pixel = $urandom_range(1) ? 8'd255 : 8'd0;
         default: pick_pixel = glmm_pkg::pixel_type'($urandom_range(255));
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // sender: advance to the next pixel once the current transaction is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            mark_cavities(req_pixel);
            pixels_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (raster_in.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_pixel <= raster_in.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to fill the block
   always @(posedge clock) begin
      if (long_hold_go && hold_count < LONG_HOLD) begin
         hold_count <= hold_count + 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_pixel   = rsp_out_pixel;
         got.end_of_row  = rsp_end_of_row;
         got.end_of_grid = rsp_end_of_grid;
         got.last_of_run = rsp_last_of_run;
         if (marked_due.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
         end else begin
            want = marked_due.pop_front();
            if (got.out_pixel !== want.out_pixel)
               flag_mismatch($sformatf("result %0d out_pixel %0d, want %0d",
                  results_seen, got.out_pixel, want.out_pixel));
            if (got.end_of_row !== want.end_of_row)
               flag_mismatch($sformatf("result %0d end_of_row %b, want %b",
                  results_seen, got.end_of_row, want.end_of_row));
            if (got.end_of_grid !== want.end_of_grid)
               flag_mismatch($sformatf("result %0d end_of_grid %b, want %b",
                  results_seen, got.end_of_grid, want.end_of_grid));
            if (got.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("result %0d last_of_run %b, want %b",
                  results_seen, got.last_of_run, want.last_of_run));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("stalled for %0d cycles with %0d results due", QUIET_LIMIT,
            marked_due.size());
         $display("grid_local_max_marker_core test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (raster_in.size() != 0 || req_valid || marked_due.size() != 0);
      // first-row pixels release nothing, so give the block time to settle
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_grid_size(input logic [glmm_pkg::GRID_SIZE_W-1:0] size);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_grid_size <= size;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      side_reg = size;
      row_at = 0;
      col_at = 0;
      sizes_written++;
   endtask

   task automatic run_phase(input logic [glmm_pkg::GRID_SIZE_W-1:0] size, input int count,
                            input bit pause_mid);
      int first;
      write_grid_size(size);
      first = pause_mid ? count / 2 : count;
      repeat (first) raster_in = {raster_in, pick_pixel()};
      if (pause_mid) begin
         wait_drained();
         repeat (count - first) raster_in = {raster_in, pick_pixel()};
      end
      wait_drained();
   endtask

   initial begin : stimulus
      int                               quota;
      int                               sent;
      int                               count;
      int                               eff;
      int                               phase;
      logic [glmm_pkg::GRID_SIZE_W-1:0] size;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // side of one after reset: every pixel is its own row and grid
      raster_in = '{8'd0, 8'd255, 8'd88};
      wait_drained();
      // zero reads as one
      write_grid_size(9'd0);
      raster_in = '{8'd1, 8'd254};
      wait_drained();
      // a clear peak, then a centre that only ties its neighbours
      write_grid_size(9'd3);
      raster_in = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd200, 8'd60, 8'd70, 8'd80, 8'd90,
                    8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};
      wait_drained();

      phase = 0;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 31;
               rsp_idle_pct = 65;
               quota = 500;
            end
            1: begin
               req_idle_pct = 65;
               rsp_idle_pct = 31;
               quota = 250;
               // clamped side: rows must still break at the largest side
               run_phase(9'd511, SIDE_MAX + 8, 1'b0);
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               quota = 200;
               run_phase(9'd256, 2 * SIDE_MAX + 40, 1'b0);
               long_hold_go = 1'b1;
               run_phase(9'd4, 64, 1'b0);
            end
         endcase
         sent = 0;
         while (sent < quota) begin
            case ($urandom_range(9))
               0: size = 9'd2;
               1: size = 9'($urandom_range(1));
               2: size = 9'($urandom_range(9, 12));
               default: size = 9'($urandom_range(3, 8));
            endcase
            eff = (size == 0) ? 1 : int'(size);
            count = eff * eff * ((eff > 8) ? 1 : $urandom_range(1, 3));
            // a broken-off grid now and then, so the next size write lands mid-grid
            if (eff > 1 && $urandom_range(3) == 0) count += $urandom_range(1, eff * eff - 1);
            if (eff == 1) count = $urandom_range(2, 8);
            run_phase(size, count, (phase % 4) == 1);
            sent += count;
            phase++;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d pixels and %0d results (%0d marked) over %0d size settings,",
         pixels_taken, results_seen, cavities_due, sizes_written);
      $display("sides 0 to 511 with clamping, mid-grid size changes and a long result hold-off.");
      if (mismatches == 0) begin
         $display("grid_local_max_marker_core test passed");
      end else begin
         $display("grid_local_max_marker_core test failed");
      end
      $finish;
   end

endmodule

// ===== grid_local_max_marker_core.f =====
rtl/core/glmm_pkg.sv
rtl/core/glmm_row_buffer.sv
rtl/core/glmm_out_queue.sv
rtl/core/grid_local_max_marker_core.sv
sim/tb.sv
